### sv/dsct_pkg.sv
// Shared constants and payload types for the debounced start cutdown timer.
`timescale 1ns / 1ps
`default_nettype none

package dsct_pkg;

    // Width of the running tick counter (8 to 32).
    localparam int TICK_WIDTH     = 16;

    localparam int DEB_WIDTH      = 8;
    localparam int CUT_WIDTH      = 16;
    localparam int ELAPSED_WIDTH  = 16;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CUTDOWN_LIMIT  = 1'd1;

    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_LIMIT_RST = 8'd254;
    localparam logic [CUT_WIDTH-1:0] CUTDOWN_LIMIT_RST  = 16'd20;

    // Mode codes as seen on run_mode
    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_STARTING = 2'd1;
    localparam logic [1:0] MODE_RUNNING  = 2'd2;

    // Debounce phase codes as seen on button_phase
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_PRESS     = 2'd1;
    localparam logic [1:0] PH_RELEASE   = 2'd2;
    localparam logic [1:0] PH_CONFIRMED = 2'd3;

    typedef struct packed {
        logic                     buzzer_on;
        logic                     led_on;
        logic                     cutter_on;
        logic [1:0]               run_mode;
        logic [1:0]               button_phase;
        logic [ELAPSED_WIDTH-1:0] elapsed_ticks;
    } t_result;

endpackage

`default_nettype wire

### sv/dsct_if.sv
// Valid/ready channel interfaces for polls in and results out.
`timescale 1ns / 1ps
`default_nettype none

interface dsct_poll_if;
    logic valid;
    logic ready;
    logic button_level;
    logic tick;

    modport source (output valid, output button_level, output tick, input ready);
    modport sink   (input valid, input button_level, input tick, output ready);
endinterface

interface dsct_result_if;
    logic                               valid;
    logic                               ready;
    logic                               buzzer_on;
    logic                               led_on;
    logic                               cutter_on;
    logic [1:0]                         run_mode;
    logic [1:0]                         button_phase;
    logic [dsct_pkg::ELAPSED_WIDTH-1:0] elapsed_ticks;

    modport source (output valid, output buzzer_on, output led_on, output cutter_on,
                    output run_mode, output button_phase, output elapsed_ticks,
                    input ready);
    modport sink   (input valid, input buzzer_on, input led_on, input cutter_on,
                    input run_mode, input button_phase, input elapsed_ticks,
                    output ready);
endinterface

`default_nettype wire

### sv/debounced_start_cutdown_timer.sv
// Top level: button debouncer, tick counter and mode machine with a result register.
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-------------
//  i_poll   | in  | button_level, tick                             | valid/ready
//  o_result | out | buzzer, led, cutter, mode, phase, elapsed      | valid/ready
//  cfg      | in  | i_cfg_index, i_cfg_data                        | i_cfg_we
//
// One poll per cycle while the output side keeps up; its result is registered and shows on o_result in the next cycle.
// The state update and the result are one combinational pass from the state registers.
// The poll side stalls only while a result waits and the output side is not ready.
// Synchronous active-low reset restores the limits to 254 and 20, LED on, mode off.
`timescale 1ns / 1ps
`default_nettype none

module debounced_start_cutdown_timer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [dsct_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [dsct_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    dsct_poll_if.sink                                i_poll,
    dsct_result_if.source                            o_result
);

    typedef enum logic [1:0] {
        S_OFF      = dsct_pkg::MODE_OFF,
        S_STARTING = dsct_pkg::MODE_STARTING,
        S_RUNNING  = dsct_pkg::MODE_RUNNING
    } t_mode;

    typedef enum logic [1:0] {
        P_IDLE      = dsct_pkg::PH_IDLE,
        P_PRESS     = dsct_pkg::PH_PRESS,
        P_RELEASE   = dsct_pkg::PH_RELEASE,
        P_CONFIRMED = dsct_pkg::PH_CONFIRMED
    } t_phase;

    logic [dsct_pkg::DEB_WIDTH-1:0]  r_debounce_limit;
    logic [dsct_pkg::CUT_WIDTH-1:0]  r_cutdown_limit;
    t_phase                          r_phase,  n_phase;
    logic [dsct_pkg::DEB_WIDTH-1:0]  r_conf,   n_conf;
    t_mode                           r_mode,   n_mode;
    logic [dsct_pkg::TICK_WIDTH-1:0] r_ticks,  n_ticks;
    logic                            r_buzzer, n_buzzer;
    logic                            r_led,    n_led;
    logic                            r_cutter, n_cutter;
    logic                            r_out_valid;
    dsct_pkg::t_result               r_out,    n_out;

    logic                            in_xfer;
    logic                            pressed;
    logic                            run_tick;
    logic [31:0]                     ticks_wide;

    assign i_poll.ready = !r_out_valid || o_result.ready;
    assign in_xfer      = i_poll.valid && i_poll.ready;
    assign pressed      = !i_poll.button_level;

    always_comb begin
        n_phase    = r_phase;
        n_conf     = r_conf;
        n_mode     = r_mode;
        n_ticks    = r_ticks;
        n_buzzer   = r_buzzer;
        n_led      = r_led;
        n_cutter   = r_cutter;
        run_tick   = i_poll.tick && (r_mode == S_RUNNING);

        // debouncer: press must hold, then release must hold
        if (pressed) begin
            unique case (r_phase)
                P_IDLE: begin
                    n_conf  = '0;
                    n_phase = P_PRESS;
                end
                P_PRESS: begin
                    if (r_conf < r_debounce_limit) n_conf = r_conf + 1'b1;
                end
                P_RELEASE:   n_conf = '0;
                P_CONFIRMED: ;
                default:     ;
            endcase
        end else begin
            unique case (r_phase)
                P_PRESS: begin
                    if (r_conf == r_debounce_limit) n_phase = P_RELEASE;
                    n_conf = '0;
                end
                P_RELEASE: begin
                    if (r_conf < r_debounce_limit) begin
                        n_conf = r_conf + 1'b1;
                    end else begin
                        n_phase = P_CONFIRMED;
                        n_conf  = '0;
                    end
                end
                P_IDLE:      ;
                P_CONFIRMED: ;
                default:     ;
            endcase
        end

        if (run_tick) begin
            if (r_ticks != '1) n_ticks = r_ticks + 1'b1;
            n_buzzer = !r_buzzer;
            n_led    = !r_led;
        end
        ticks_wide = 32'(n_ticks);
        if (run_tick && (ticks_wide > 32'(r_cutdown_limit))) n_cutter = 1'b1;

        unique case (r_mode)
            S_OFF: begin
                if (n_phase == P_CONFIRMED) begin
                    n_phase = P_IDLE;
                    n_mode  = S_STARTING;
                end
            end
            S_STARTING: n_mode = S_RUNNING;
            S_RUNNING:  ;
            default:    ;
        endcase

        n_out.buzzer_on     = n_buzzer;
        n_out.led_on        = n_led;
        n_out.cutter_on     = n_cutter;
        n_out.run_mode      = n_mode;
        n_out.button_phase  = n_phase;
        n_out.elapsed_ticks = ticks_wide[dsct_pkg::ELAPSED_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= dsct_pkg::DEBOUNCE_LIMIT_RST;
            r_cutdown_limit  <= dsct_pkg::CUTDOWN_LIMIT_RST;
            r_phase          <= P_IDLE;
            r_conf           <= '0;
            r_mode           <= S_OFF;
            r_ticks          <= '0;
            r_buzzer         <= 1'b0;
            r_led            <= 1'b1;
            r_cutter         <= 1'b0;
            r_out_valid      <= 1'b0;
            r_out            <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dsct_pkg::REG_DEBOUNCE_LIMIT:
                        r_debounce_limit <= i_cfg_data[dsct_pkg::DEB_WIDTH-1:0];
                    dsct_pkg::REG_CUTDOWN_LIMIT:
                        r_cutdown_limit  <= i_cfg_data[dsct_pkg::CUT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_phase  <= n_phase;
                r_conf   <= n_conf;
                r_mode   <= n_mode;
                r_ticks  <= n_ticks;
                r_buzzer <= n_buzzer;
                r_led    <= n_led;
                r_cutter <= n_cutter;
                r_out    <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.buzzer_on     = r_out.buzzer_on;
    assign o_result.led_on        = r_out.led_on;
    assign o_result.cutter_on     = r_out.cutter_on;
    assign o_result.run_mode      = r_out.run_mode;
    assign o_result.button_phase  = r_out.button_phase;
    assign o_result.elapsed_ticks = r_out.elapsed_ticks;

endmodule

`default_nettype wire

### sv/dsct_checker.sv
// Port-level checks for the debounced start cutdown timer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dsct_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_res_valid,
    input wire logic                               i_res_ready,
    input wire logic                               i_buzzer_on,
    input wire logic                               i_led_on,
    input wire logic                               i_cutter_on,
    input wire logic [1:0]                         i_run_mode,
    input wire logic [dsct_pkg::ELAPSED_WIDTH-1:0] i_elapsed_ticks
);

    logic r_cutter_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutter_seen <= 1'b0;
        end else if (i_res_valid && i_res_ready && i_cutter_on) begin
            r_cutter_seen <= 1'b1;
        end
    end

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_elapsed_ticks)
            && $stable(i_run_mode) && $stable(i_cutter_on))
        else $error("stalled result changed");

    // buzzer and LED start opposite and always toggle together
    a_buzz_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_led_on != i_buzzer_on))
        else $error("buzzer and LED out of step");

    // cutter is latched across transfers
    a_cutter_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && r_cutter_seen |-> i_cutter_on)
        else $error("cutter dropped after latching");

    // ticks and cutter only move while running
    a_run_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_cutter_on || i_elapsed_ticks != '0)
            |-> i_run_mode == dsct_pkg::MODE_RUNNING)
        else $error("tick activity outside running mode");

endmodule

bind debounced_start_cutdown_timer dsct_checker u_dsct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_result.valid),
    .i_res_ready     (o_result.ready),
    .i_buzzer_on     (o_result.buzzer_on),
    .i_led_on        (o_result.led_on),
    .i_cutter_on     (o_result.cutter_on),
    .i_run_mode      (o_result.run_mode),
    .i_elapsed_ticks (o_result.elapsed_ticks)
);

`default_nettype wire

### dv/tb_top.sv
// Testbench for debounced_start_cutdown_timer: random polls checked against a built-in predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT     = 60;    // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic button_level;
        logic tick;
    } t_poll;

    logic                                i_clk     = 1'b0;
    logic                                i_rst_n   = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [dsct_pkg::CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [dsct_pkg::CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    dsct_poll_if   poll_ch ();
    dsct_result_if result_ch ();

    debounced_start_cutdown_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_poll      (poll_ch),
        .o_result    (result_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state and its copy of the limits
    logic [dsct_pkg::DEB_WIDTH-1:0]  lim_debounce;
    logic [dsct_pkg::CUT_WIDTH-1:0]  lim_cutdown;
    logic [1:0]                      btn_phase;
    logic [dsct_pkg::DEB_WIDTH-1:0]  btn_conf;
    logic [1:0]                      op_mode;
    logic [dsct_pkg::TICK_WIDTH-1:0] tick_count;
    logic                            buzzer_lvl;
    logic                            led_lvl;
    logic                            cutter_lvl;

    t_poll             poll_q[$];
    dsct_pkg::t_result status_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_errors  = 0;
    int n_results = 0;
    int n_cycles  = 0;
    int hold_left;
    bit hold_armed;

    function automatic dsct_pkg::t_result advance_timer(logic button_level, logic tick);
        dsct_pkg::t_result st;
        if (!button_level) begin
            case (btn_phase)
                dsct_pkg::PH_IDLE: begin
                    btn_conf  = '0;
                    btn_phase = dsct_pkg::PH_PRESS;
                end
                dsct_pkg::PH_PRESS: if (btn_conf < lim_debounce) btn_conf++;
                dsct_pkg::PH_RELEASE: btn_conf = '0;
                default: ;
            endcase
        end else begin
            case (btn_phase)
                dsct_pkg::PH_PRESS: begin
                    if (btn_conf == lim_debounce) btn_phase = dsct_pkg::PH_RELEASE;
                    btn_conf = '0;
                end
                dsct_pkg::PH_RELEASE: begin
                    if (btn_conf < lim_debounce) begin
                        btn_conf++;
                    end else begin
                        btn_phase = dsct_pkg::PH_CONFIRMED;
                        btn_conf  = '0;
                    end
                end
                default: ;
            endcase
        end

        if (tick && op_mode == dsct_pkg::MODE_RUNNING) begin
            if (tick_count != '1) tick_count++;
            buzzer_lvl = ~buzzer_lvl;
            led_lvl    = ~led_lvl;
            if (tick_count > lim_cutdown) cutter_lvl = 1'b1;
        end

        // a confirmed press is only consumed while off
        if (op_mode == dsct_pkg::MODE_OFF) begin
            if (btn_phase == dsct_pkg::PH_CONFIRMED) begin
                btn_phase = dsct_pkg::PH_IDLE;
                op_mode   = dsct_pkg::MODE_STARTING;
            end
        end else if (op_mode == dsct_pkg::MODE_STARTING) begin
            op_mode = dsct_pkg::MODE_RUNNING;
        end

        st.buzzer_on     = buzzer_lvl;
        st.led_on        = led_lvl;
        st.cutter_on     = cutter_lvl;
        st.run_mode      = op_mode;
        st.button_phase  = btn_phase;
        st.elapsed_ticks = dsct_pkg::ELAPSED_WIDTH'(tick_count);
        return st;
    endfunction

    task automatic report(string msg);
        if (n_errors < MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Poll driver: predicts each transfer, then offers the next pending poll
    always @(posedge i_clk) begin : poll_driver
        t_poll nxt;
        if (!i_rst_n) begin
            poll_ch.valid        <= 1'b0;
            poll_ch.button_level <= 1'b1;
            poll_ch.tick         <= 1'b0;
            btn_phase  = dsct_pkg::PH_IDLE;
            btn_conf   = '0;
            op_mode    = dsct_pkg::MODE_OFF;
            tick_count = '0;
            buzzer_lvl = 1'b0;
            led_lvl    = 1'b1;
            cutter_lvl = 1'b0;
        end else if (!poll_ch.valid || poll_ch.ready) begin
            if (poll_ch.valid) begin
                status_q.push_back(advance_timer(poll_ch.button_level, poll_ch.tick));
            end
            if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = poll_q.pop_front();
                poll_ch.valid        <= 1'b1;
                poll_ch.button_level <= nxt.button_level;
                poll_ch.tick         <= nxt.tick;
            end else begin
                poll_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the result register fills and the poll side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && n_results == HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        dsct_pkg::t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                n_results <= n_results + 1;
                if (status_q.size() == 0) begin
                    report("result transfer with nothing expected");
                end else begin
                    want = status_q.pop_front();
                    check_field("buzzer_on", result_ch.buzzer_on, want.buzzer_on);
                    check_field("led_on", result_ch.led_on, want.led_on);
                    check_field("cutter_on", result_ch.cutter_on, want.cutter_on);
                    check_field("run_mode", result_ch.run_mode, want.run_mode);
                    check_field("button_phase", result_ch.button_phase, want.button_phase);
                    check_field("elapsed_ticks", result_ch.elapsed_ticks, want.elapsed_ticks);
                end
            end
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("debounced_start_cutdown_timer test failed");
            $finish;
        end
    end

    function automatic void push_poll(logic button_level, logic tick);
        t_poll p;
        p.button_level = button_level;
        p.tick         = tick;
        poll_q.push_back(p);
    endfunction

    function automatic void push_run(logic button_level, int len, int tick_pct);
        repeat (len) push_poll(button_level, $urandom_range(99) < tick_pct);
    endfunction

    // Press/release runs that never hold a release long enough to confirm,
    // so the block stays off; ends on a press to clear any release count.
    function automatic void push_off_noise(int lim, int n_items);
        int first;
        int p_len;
        int r_len;
        first = poll_q.size();
        while (poll_q.size() - first < n_items) begin
            if ($urandom_range(5) == 0) begin
                p_len = $urandom_range(1, lim + 2);
            end else begin
                p_len = $urandom_range(lim > 1 ? lim - 1 : 1, lim + 2);
            end
            push_run(1'b0, p_len, 50);
            r_len = $urandom_range(1, lim < 10 ? lim : 10);
            push_run(1'b1, r_len, 50);
            if ($urandom_range(3) == 0) push_run(1'b0, 1, 50);
        end
        push_run(1'b0, 1, 50);
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (poll_q.size() != 0 || poll_ch.valid || status_q.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [dsct_pkg::CFG_IDX_WIDTH-1:0] index,
                             logic [dsct_pkg::CFG_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        if (index == dsct_pkg::REG_DEBOUNCE_LIMIT) lim_debounce = data[dsct_pkg::DEB_WIDTH-1:0];
        else lim_cutdown = data[dsct_pkg::CUT_WIDTH-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // upper data bits are noise for the 8-bit register
    task automatic write_debounce(int lim);
        write_reg(dsct_pkg::REG_DEBOUNCE_LIMIT,
                  (dsct_pkg::CFG_DATA_WIDTH'($urandom) << dsct_pkg::DEB_WIDTH)
                  | dsct_pkg::CFG_DATA_WIDTH'(lim));
    endtask

    initial begin : stimulus
        int lims[5];
        logic [dsct_pkg::CUT_WIDTH-1:0] cut;

        poll_ch.valid        = 1'b0;
        poll_ch.button_level = 1'b1;
        poll_ch.tick         = 1'b0;
        result_ch.ready      = 1'b0;
        lim_debounce  = dsct_pkg::DEBOUNCE_LIMIT_RST;
        lim_cutdown   = dsct_pkg::CUTDOWN_LIMIT_RST;
        send_idle_pct = 11;
        recv_idle_pct = 64;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limits: ticks ignored while off, early release drops confidence
        push_poll(1'b1, 1'b1);
        push_poll(1'b1, 1'b0);
        push_poll(1'b0, 1'b1);
        push_poll(1'b0, 1'b0);
        push_poll(1'b0, 1'b1);
        push_poll(1'b1, 1'b0);
        push_poll(1'b1, 1'b1);
        push_poll(1'b0, 1'b0);
        wait_drained();

        // Debouncer exercised while still off, over several limits
        lims = '{1, 3, $urandom_range(2, 8), 255, $urandom_range(1, 6)};
        foreach (lims[k]) begin
            write_debounce(lims[k]);
            write_reg(dsct_pkg::REG_CUTDOWN_LIMIT, dsct_pkg::CFG_DATA_WIDTH'($urandom));
            push_off_noise(lims[k], lims[k] == 255 ? 1 : 50);
            wait_drained();
        end

        // Zero debounce limit: start up, then a press that reaches the release phase while running
        send_idle_pct = 64;
        recv_idle_pct = 11;
        write_debounce(0);
        write_reg(dsct_pkg::REG_CUTDOWN_LIMIT, '1);
        push_poll(1'b1, 1'b0);
        push_poll(1'b1, 1'b1);
        push_poll(1'b1, 1'b0);
        push_poll(1'b1, 1'b1);
        push_poll(1'b1, 1'b0);
        push_poll(1'b0, 1'b1);
        push_poll(1'b1, 1'b1);
        push_poll(1'b0, 1'b0);
        push_poll(1'b1, 1'b1);
        push_poll(1'b0, 1'b1);
        push_poll(1'b1, 1'b1);
        wait_drained();

        // Running: cutter limit well above the count, then near it, then zero
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: cut = dsct_pkg::CUT_WIDTH'(65534);
                1: cut = dsct_pkg::CUT_WIDTH'($urandom_range(int'(tick_count) + 200, 65533));
                2: cut = dsct_pkg::CUT_WIDTH'(int'(tick_count) + $urandom_range(1, 20));
                default: cut = '0;
            endcase
            write_debounce($urandom_range(255));
            write_reg(dsct_pkg::REG_CUTDOWN_LIMIT, dsct_pkg::CFG_DATA_WIDTH'(cut));
            repeat (k == 3 ? 20 : 40) push_poll($urandom_range(1), $urandom_range(9) < 7);
            wait_drained();
        end

        // Back-to-back polls with neither side idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (40) push_poll($urandom_range(1), $urandom_range(1));
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("debounced_start_cutdown_timer test passed");
        end else begin
            $display("debounced_start_cutdown_timer test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/dsct_pkg.sv
sv/dsct_if.sv
sv/debounced_start_cutdown_timer.sv
sv/dsct_checker.sv
dv/tb_top.sv
